/* rtl/bounded_double_ended_queue_macros.svh */
// ----------------------------------------------------------------------------
// Bounded double-ended queue assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BDEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BDEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bdeq_pkg.sv */
// ----------------------------------------------------------------------------
// Bounded double-ended queue package
// Item types, operation codes and status codes shared by the design.
// ----------------------------------------------------------------------------
`default_nettype none

package bdeq_pkg;

    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int CAP_W    = 5;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PEEK_REAR  = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [STATUS_W-1:0]      status;
        logic [OCC_W-1:0]         occupancy;
    } t_out_item;

endpackage

`default_nettype wire

/* rtl/bdeq_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic                                       i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/bounded_double_ended_queue.sv */
// ----------------------------------------------------------------------------
// Bounded double-ended queue
// Ring-store deque of signed 32-bit words with a writable capacity limit.
// ----------------------------------------------------------------------------
// The block handles one item at a time. A push is written to the ring RAM in
// the cycle it is accepted and its result is offered in the next cycle; a pop
// or peek on a non-empty queue reads the RAM, whose registered read adds the
// ST_READ state, so its result is offered from ST_OUT after ST_READ. A new
// item is accepted in the cycle after the result is taken. The capacity limit
// in use is the capacity register clamped to DEPTH, and a value of zero
// refuses every push.
`default_nettype none

module bounded_double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bdeq_pkg::CAP_W-1:0]      i_cfg_wdata,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire bdeq_pkg::t_in_item              i_in_item,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output bdeq_pkg::t_out_item                  o_out_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int LW = (CW > bdeq_pkg::CAP_W) ? CW : bdeq_pkg::CAP_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_OUT
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [bdeq_pkg::CAP_W-1:0] r_capacity;
    bdeq_pkg::t_out_item r_out, n_out;

    logic                ram_we;
    logic                ram_re;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [bdeq_pkg::DATA_W-1:0] ram_rdata;

    logic [AW-1:0]       head_dec;
    logic [AW-1:0]       head_inc;
    logic [SW-1:0]       push_sum;
    logic [SW-1:0]       last_sum;
    logic [AW-1:0]       rear_push_addr;
    logic [AW-1:0]       rear_last_addr;
    logic [LW-1:0]       limit;
    logic [LW-1:0]       count_ext;
    logic                is_full;
    logic                is_empty;

    always_comb begin
        head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
        head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
        push_sum = SW'(r_head) + SW'(r_count);
        last_sum = push_sum - SW'(1);
        rear_push_addr = (push_sum >= SW'(DEPTH)) ? AW'(push_sum - SW'(DEPTH))
                                                  : AW'(push_sum);
        rear_last_addr = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH))
                                                  : AW'(last_sum);
        limit = (LW'(r_capacity) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(r_capacity);
        count_ext = LW'(r_count);
        is_full  = (count_ext >= limit);
        is_empty = (r_count == '0);
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_out     = r_out;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = rear_push_addr;
        ram_raddr = r_head;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_out.data   = '0;
                    n_out.status = bdeq_pkg::STATUS_OK;
                    n_state      = ST_OUT;
                    case (i_in_item.kind)
                        bdeq_pkg::KIND_PUSH_FRONT, bdeq_pkg::KIND_PUSH_REAR: begin
                            if (is_full) begin
                                n_out.status = bdeq_pkg::STATUS_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + CW'(1);
                                if (i_in_item.kind == bdeq_pkg::KIND_PUSH_FRONT) begin
                                    ram_waddr = head_dec;
                                    n_head    = head_dec;
                                end
                            end
                        end
                        bdeq_pkg::KIND_POP_FRONT, bdeq_pkg::KIND_POP_REAR,
                        bdeq_pkg::KIND_PEEK_FRONT, bdeq_pkg::KIND_PEEK_REAR: begin
                            if (is_empty) begin
                                n_out.status = bdeq_pkg::STATUS_EMPTY;
                            end else begin
                                ram_re  = 1'b1;
                                n_state = ST_READ;
                                if (i_in_item.kind == bdeq_pkg::KIND_POP_REAR ||
                                    i_in_item.kind == bdeq_pkg::KIND_PEEK_REAR) begin
                                    ram_raddr = rear_last_addr;
                                end
                                if (i_in_item.kind == bdeq_pkg::KIND_POP_FRONT) begin
                                    n_head  = head_inc;
                                    n_count = r_count - CW'(1);
                                end
                                if (i_in_item.kind == bdeq_pkg::KIND_POP_REAR) begin
                                    n_count = r_count - CW'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out.occupancy = bdeq_pkg::OCC_W'(n_count);
                end
            end
            ST_READ: begin
                n_out.data = $signed(ram_rdata);
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= '0;
            r_count    <= '0;
            r_capacity <= bdeq_pkg::CAP_RESET;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
        end
    end

    bdeq_ram #(
        .WIDTH(bdeq_pkg::DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_in_item.value),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

/* rtl/bdeq_chk.sv */
// ----------------------------------------------------------------------------
// Bounded double-ended queue port checker
// Port-level properties of the deque, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_double_ended_queue_macros.svh"

module bdeq_chk (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire bdeq_pkg::t_out_item o_out_item
);

    logic in_take;
    logic out_take;
    logic out_empty;
    logic out_full;
    logic empty_clean;

    assign in_take     = i_in_valid && o_in_ready;
    assign out_take    = o_out_valid && i_out_ready;
    assign out_empty   = o_out_valid && (o_out_item.status == bdeq_pkg::STATUS_EMPTY);
    assign out_full    = o_out_valid && (o_out_item.status == bdeq_pkg::STATUS_FULL);
    assign empty_clean = (o_out_item.data == '0) && (o_out_item.occupancy == '0);

    `BDEQ_ASSERT_NOW(a_one_in_flight, o_out_valid, !o_in_ready, "Ready while a result waits.")
    `BDEQ_ASSERT_NEXT(a_busy_after_accept, in_take, !o_in_ready, "Ready after an accepted item.")
    `BDEQ_ASSERT_NEXT(a_out_drops, out_take, !o_out_valid, "Result offered twice.")
    `BDEQ_ASSERT_NOW(a_empty_result, out_empty, empty_clean, "Empty result carries data or count.")
    `BDEQ_ASSERT_NOW(a_full_result, out_full, o_out_item.data == '0, "Refused push carries data.")

endmodule

bind bounded_double_ended_queue bdeq_chk u_bdeq_chk (.*);

`default_nettype wire

/* tb/sv/bounded_double_ended_queue_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded double-ended queue testbench
// Drives push, pop and peek items through the deque under several capacity
// settings and random idling on both channels. A shadow copy of the ring
// store predicts every result, and each accepted result is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_double_ended_queue_tb;

    localparam int RING_DEPTH       = 16;
    localparam int STALL_LIMIT      = 4000;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int SEGMENT_ITEMS    = 280;
    localparam int SEGMENTS         = 6;
    localparam int SETTLE_CYCLES    = 4;

    localparam logic [bdeq_pkg::KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [bdeq_pkg::KIND_W-1:0] KIND_SPARE_B = 3'd7;

    class deque_shadow;
        logic [bdeq_pkg::DATA_W-1:0] ring [RING_DEPTH];
        int unsigned                 head;
        int unsigned                 count;
        int unsigned                 cap_reg;
        int unsigned                 errors;
        bdeq_pkg::t_out_item         pending_responses [$];

        function new();
            head    = 0;
            count   = 0;
            cap_reg = 32'(bdeq_pkg::CAP_RESET);
            errors  = 0;
        endfunction

        function void set_capacity(logic [bdeq_pkg::CAP_W-1:0] cap);
            cap_reg = 32'(cap);
        endfunction

        function void note_request(bdeq_pkg::t_in_item req);
            bdeq_pkg::t_out_item resp;
            int unsigned         limit;
            int unsigned         pos;
            resp  = '0;
            limit = (cap_reg > RING_DEPTH) ? RING_DEPTH : cap_reg;
            case (req.kind)
                bdeq_pkg::KIND_PUSH_FRONT, bdeq_pkg::KIND_PUSH_REAR: begin
                    if (count >= limit) begin
                        resp.status = bdeq_pkg::STATUS_FULL;
                    end else begin
                        if (req.kind == bdeq_pkg::KIND_PUSH_FRONT) begin
                            head       = (head + RING_DEPTH - 1) % RING_DEPTH;
                            ring[head] = req.value;
                        end else begin
                            ring[(head + count) % RING_DEPTH] = req.value;
                        end
                        count++;
                    end
                end
                bdeq_pkg::KIND_POP_FRONT, bdeq_pkg::KIND_POP_REAR,
                bdeq_pkg::KIND_PEEK_FRONT, bdeq_pkg::KIND_PEEK_REAR: begin
                    if (count == 0) begin
                        resp.status = bdeq_pkg::STATUS_EMPTY;
                    end else begin
                        if (req.kind == bdeq_pkg::KIND_POP_FRONT ||
                            req.kind == bdeq_pkg::KIND_PEEK_FRONT) begin
                            pos = head;
                        end else begin
                            pos = (head + count - 1) % RING_DEPTH;
                        end
                        resp.data = ring[pos];
                        if (req.kind == bdeq_pkg::KIND_POP_FRONT) begin
                            head = (head + 1) % RING_DEPTH;
                            count--;
                        end else if (req.kind == bdeq_pkg::KIND_POP_REAR) begin
                            count--;
                        end
                    end
                end
                default: begin
                end
            endcase
            resp.occupancy = bdeq_pkg::OCC_W'(count);
            pending_responses.push_back(resp);
        endfunction

        function void flag(string field, logic [bdeq_pkg::DATA_W-1:0] want,
                           logic [bdeq_pkg::DATA_W-1:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        endfunction

        function void check_response(bdeq_pkg::t_out_item got);
            bdeq_pkg::t_out_item want;
            if (pending_responses.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, expected none, actual %h", $time, got);
                return;
            end
            want = pending_responses.pop_front();
            if (got.data !== want.data) begin
                flag("data", want.data, got.data);
            end
            if (got.status !== want.status) begin
                flag("status", bdeq_pkg::DATA_W'(want.status),
                     bdeq_pkg::DATA_W'(got.status));
            end
            if (got.occupancy !== want.occupancy) begin
                flag("occupancy", bdeq_pkg::DATA_W'(want.occupancy),
                     bdeq_pkg::DATA_W'(got.occupancy));
            end
        endfunction
    endclass

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [bdeq_pkg::CAP_W-1:0] i_cfg_wdata = '0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_ready;
    bdeq_pkg::t_in_item         i_in_item   = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    bdeq_pkg::t_out_item        o_out_item;

    int unsigned in_idle_pct  = 0;
    int unsigned out_idle_pct = 0;
    bit          hold_off_req = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned quiet_cycles = 0;

    deque_shadow shadow = new();

    bounded_double_ended_queue #(
        .DEPTH(RING_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                shadow.check_response(o_out_item);
            end
            if (i_in_valid && o_in_ready) begin
                shadow.note_request(i_in_item);
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    task automatic send_request(input logic [bdeq_pkg::KIND_W-1:0] kind,
                                input logic [bdeq_pkg::DATA_W-1:0] value);
        bdeq_pkg::t_in_item req;
        req.kind  = kind;
        req.value = value;
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (shadow.pending_responses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [bdeq_pkg::CAP_W-1:0] cap);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow.set_capacity(cap);
    endtask

    function automatic bdeq_pkg::t_in_item random_request(bit filling);
        bdeq_pkg::t_in_item req;
        int unsigned        pick;
        int unsigned        push_pct;
        pick     = $urandom_range(99);
        push_pct = filling ? 65 : 20;
        if (pick < 3) begin
            req.kind = $urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B;
        end else if (pick < 3 + push_pct) begin
            req.kind = $urandom_range(1) ? bdeq_pkg::KIND_PUSH_FRONT
                                         : bdeq_pkg::KIND_PUSH_REAR;
        end else if (pick < 88) begin
            req.kind = $urandom_range(1) ? bdeq_pkg::KIND_POP_FRONT
                                         : bdeq_pkg::KIND_POP_REAR;
        end else begin
            req.kind = $urandom_range(1) ? bdeq_pkg::KIND_PEEK_FRONT
                                         : bdeq_pkg::KIND_PEEK_REAR;
        end
        case ($urandom_range(9))
            0:       req.value = 32'h7fff_ffff;
            1:       req.value = 32'h8000_0000;
            2:       req.value = 32'hffff_ffff;
            3:       req.value = 32'h0000_0000;
            default: req.value = $urandom;
        endcase
        return req;
    endfunction

    initial begin
        logic [bdeq_pkg::CAP_W-1:0] seg_caps [SEGMENTS];
        int                         seg;
        int                         n;
        int unsigned                burst_left;
        bit                         filling;
        bdeq_pkg::t_in_item         req;

        seg_caps   = '{5'd31, 5'd4, 5'd16, 5'd1, 5'd0, 5'd12};
        seg_caps[4] = bdeq_pkg::CAP_W'($urandom_range(31));
        burst_left = 0;
        filling    = 1'b1;
        in_idle_pct  = 19;
        out_idle_pct = 71;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty queue, both ends, extreme words and the spare kinds at reset capacity.
        send_request(bdeq_pkg::KIND_POP_FRONT,  32'h5a5a_5a5a);
        send_request(bdeq_pkg::KIND_POP_REAR,   32'ha5a5_a5a5);
        send_request(bdeq_pkg::KIND_PEEK_FRONT, 32'hffff_ffff);
        send_request(bdeq_pkg::KIND_PEEK_REAR,  32'h0000_0000);
        send_request(bdeq_pkg::KIND_PUSH_FRONT, 32'h7fff_ffff);
        send_request(bdeq_pkg::KIND_PUSH_REAR,  32'h8000_0000);
        send_request(bdeq_pkg::KIND_PUSH_FRONT, 32'hffff_ffff);
        send_request(bdeq_pkg::KIND_PUSH_REAR,  32'h0000_0000);
        send_request(bdeq_pkg::KIND_PEEK_FRONT, 32'h1234_5678);
        send_request(bdeq_pkg::KIND_PEEK_REAR,  32'h1234_5678);
        send_request(KIND_SPARE_A,              32'hdead_beef);
        send_request(KIND_SPARE_B,              32'hffff_ffff);
        send_request(bdeq_pkg::KIND_POP_REAR,   32'h0000_0000);
        send_request(bdeq_pkg::KIND_POP_FRONT,  32'h0000_0000);
        wait_quiet();

        // Capacity equal to the fill level, then lowered below it, then zero.
        write_capacity(5'd2);
        send_request(bdeq_pkg::KIND_PUSH_REAR, 32'h0000_0001);
        wait_quiet();
        write_capacity(5'd1);
        send_request(bdeq_pkg::KIND_PUSH_FRONT, 32'h0000_0002);
        send_request(bdeq_pkg::KIND_POP_FRONT,  32'h0000_0000);
        send_request(bdeq_pkg::KIND_PUSH_REAR,  32'h0000_0003);
        send_request(bdeq_pkg::KIND_POP_REAR,   32'h0000_0000);
        send_request(bdeq_pkg::KIND_PUSH_FRONT, 32'h0000_0055);
        wait_quiet();
        write_capacity(5'd0);
        send_request(bdeq_pkg::KIND_PUSH_REAR,  32'h7fff_ffff);
        send_request(bdeq_pkg::KIND_PEEK_FRONT, 32'h0000_0000);
        wait_quiet();

        for (seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 2)
                0: begin
                    in_idle_pct  = 19;
                    out_idle_pct = 71;
                end
                1: begin
                    in_idle_pct  = 71;
                    out_idle_pct = 19;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            write_capacity(seg_caps[seg]);
            for (n = 0; n < SEGMENT_ITEMS; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(60, 10);
                    filling    = ~filling;
                end
                burst_left--;
                if (seg == SEGMENTS - 1 && n == 100) begin
                    hold_off_req = 1'b1;
                end
                req = random_request(filling);
                send_request(req.kind, req.value);
            end
            wait_quiet();
        end

        if (shadow.errors == 0 && shadow.pending_responses.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* bounded_double_ended_queue.f */
+incdir+rtl
rtl/bdeq_pkg.sv
rtl/bdeq_ram.sv
rtl/bounded_double_ended_queue.sv
rtl/bdeq_chk.sv
tb/sv/bounded_double_ended_queue_tb.sv
